/* src/smbios_record_walker_macros.svh */
// Assertion macros for the checker file.
`ifndef SMBIOS_RECORD_WALKER_MACROS_SVH
`define SMBIOS_RECORD_WALKER_MACROS_SVH

// Same-cycle implication, sampled on clk, quiet while in reset.
`define SMBW_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("smbw check failed: same-cycle rule");

// Next-cycle implication, sampled on clk, quiet while in reset.
`define SMBW_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("smbw check failed: next-cycle rule");

`endif

/* src/smbw_pkg.sv */
package smbw_pkg;

	// Configuration register indexes
	localparam int CFG_ADDR_W = 1;
	localparam logic [CFG_ADDR_W-1:0] REG_WANTED_HANDLE = 1'b0;
	localparam logic [CFG_ADDR_W-1:0] REG_TABLE_LENGTH  = 1'b1;

	localparam logic [15:0] NO_HANDLE  = 16'hFFFF;
	localparam logic [31:0] OFFSET_MAX = 32'hFFFF_FFFF;

	// Result status codes
	localparam logic [1:0] ST_FOUND     = 2'd0;
	localparam logic [1:0] ST_FIRST     = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;

	localparam int OUT_BITS = 66;
	localparam int OUT_W    = 72;

	typedef enum logic [4:0] {
		PH_IDLE      = 5'b00001,
		PH_HEADER    = 5'b00010,
		PH_FORMATTED = 5'b00100,
		PH_STRINGS   = 5'b01000,
		PH_NEXT      = 5'b10000
	} phase_t;

	typedef struct packed {
		logic [15:0] record_length;
		logic [31:0] record_offset;
		logic [15:0] next_handle;
		logic [1:0]  status;
	} result_t;

	// Byte held in the input stage
	typedef struct packed {
		logic       valid;
		logic       start;
		logic [7:0] data;
	} in_item_t;

	// Parser to output stage
	typedef struct packed {
		logic    load;
		result_t res;
	} out_load_t;

endpackage

/* src/smbw_in_reg.sv */
module smbw_in_reg
	import smbw_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,
	input  logic       s_tuser,
	input  logic       consume,
	output in_item_t   item
);

	logic       valid_s1;
	logic       start_s1;
	logic [7:0] data_s1;
	logic       take;

	// Take a new item when the stage is empty or drains this cycle
	assign s_tready = !valid_s1 || consume;
	assign take     = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (consume) begin
			valid_s1 <= 1'b0;
		end
	end

	// Payload needs no reset
	always_ff @(posedge clk) begin
		if (take) begin
			start_s1 <= s_tuser;
			data_s1  <= s_tdata;
		end
	end

	assign item = '{valid: valid_s1, start: start_s1, data: data_s1};

endmodule

/* src/smbw_parser.sv */
module smbw_parser
	import smbw_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  in_item_t    item,
	input  logic        out_free,
	input  logic [15:0] wanted_handle,
	input  logic [31:0] table_length,
	output logic        consume,
	output out_load_t   out_load
);

	logic [31:0] byte_offset_q;
	logic [31:0] record_begin_q;
	phase_t      phase_q;
	logic [1:0]  header_index_q;
	logic [7:0]  formatted_left_q;
	logic [7:0]  handle_lo_q;
	logic        last_zero_q;
	logic        match_seen_q;
	logic [31:0] match_begin_q;
	logic [15:0] match_length_q;

	// State as seen by this byte, after a start flag clears it
	logic [31:0] c_offset, c_begin, c_mbegin;
	phase_t      c_phase;
	logic [1:0]  c_index;
	logic [7:0]  c_left, c_hlo;
	logic        c_lz, c_mseen;
	logic [15:0] c_mlen;

	logic [31:0] n_offset, n_begin, n_mbegin;
	phase_t      n_phase;
	logic [1:0]  n_index;
	logic [7:0]  n_left, n_hlo;
	logic        n_lz, n_mseen;
	logic [15:0] n_mlen;

	logic [32:0] next_off;
	logic [32:0] len_w;
	logic [15:0] len_sat;
	logic [15:0] handle_full;
	logic        at_end;
	logic        emit;
	result_t     res;

	// Pick the starting view of the state
	always_comb begin
		if (item.start) begin
			c_offset = '0;
			c_begin  = '0;
			c_phase  = PH_HEADER;
			c_index  = '0;
			c_left   = '0;
			c_hlo    = '0;
			c_lz     = 1'b0;
			c_mseen  = 1'b0;
			c_mbegin = '0;
			c_mlen   = '0;
		end else begin
			c_offset = byte_offset_q;
			c_begin  = record_begin_q;
			c_phase  = phase_q;
			c_index  = header_index_q;
			c_left   = formatted_left_q;
			c_hlo    = handle_lo_q;
			c_lz     = last_zero_q;
			c_mseen  = match_seen_q;
			c_mbegin = match_begin_q;
			c_mlen   = match_length_q;
		end
	end

	// Offsets after this byte and the length of a matched record
	assign next_off    = {1'b0, c_offset} + 33'd1;
	assign len_w       = next_off - {1'b0, c_mbegin};
	assign len_sat     = (|len_w[32:16]) ? 16'hFFFF : len_w[15:0];
	assign at_end      = next_off >= {1'b0, table_length};
	assign handle_full = {item.data, c_hlo};

	// Walk one byte through the record grammar
	always_comb begin
		n_offset = c_offset;
		n_begin  = c_begin;
		n_phase  = c_phase;
		n_index  = c_index;
		n_left   = c_left;
		n_hlo    = c_hlo;
		n_lz     = c_lz;
		n_mseen  = c_mseen;
		n_mbegin = c_mbegin;
		n_mlen   = c_mlen;
		emit     = 1'b0;
		res      = '0;

		if (item.start && wanted_handle != NO_HANDLE && table_length == '0) begin
			// Empty table: report at once
			emit = 1'b1;
			res  = '{record_length: '0, record_offset: '0,
				next_handle: NO_HANDLE, status: ST_NOT_FOUND};
		end else if (c_phase != PH_IDLE) begin
			if (c_offset != OFFSET_MAX) begin
				n_offset = next_off[31:0];
			end
			case (c_phase)
				PH_HEADER: begin
					n_index = c_index + 2'd1;
					if (c_index == 2'd1) begin
						n_left = (item.data < 8'd4) ? 8'd0 : item.data - 8'd4;
					end else if (c_index == 2'd2) begin
						n_hlo = item.data;
					end else if (c_index == 2'd3) begin
						if (wanted_handle == NO_HANDLE) begin
							emit = 1'b1;
							res  = '{record_length: '0, record_offset: '0,
								next_handle: handle_full, status: ST_FIRST};
						end else begin
							if (handle_full == wanted_handle) begin
								n_mseen  = 1'b1;
								n_mbegin = c_begin;
							end
							n_index = '0;
							n_lz    = 1'b0;
							n_phase = (c_left != '0) ? PH_FORMATTED : PH_STRINGS;
						end
					end
				end
				PH_FORMATTED: begin
					n_left = c_left - 8'd1;
					if (c_left == 8'd1) begin
						n_lz    = 1'b0;
						n_phase = PH_STRINGS;
					end
				end
				PH_STRINGS: begin
					if (item.data == '0 && c_lz) begin
						n_index = '0;
						if (c_mseen) begin
							n_mlen = len_sat;
							if (at_end) begin
								emit = 1'b1;
								res  = '{record_length: len_sat, record_offset: c_mbegin,
									next_handle: NO_HANDLE, status: ST_FOUND};
							end else begin
								n_phase = PH_NEXT;
							end
						end else if (at_end) begin
							emit = 1'b1;
							res  = '{record_length: '0, record_offset: '0,
								next_handle: NO_HANDLE, status: ST_NOT_FOUND};
						end else begin
							n_begin = next_off[31:0];
							n_phase = PH_HEADER;
						end
					end else begin
						n_lz = (item.data == '0);
					end
				end
				PH_NEXT: begin
					n_index = c_index + 2'd1;
					if (c_index == 2'd2) begin
						n_hlo = item.data;
					end else if (c_index == 2'd3) begin
						emit = 1'b1;
						res  = '{record_length: c_mlen, record_offset: c_mbegin,
							next_handle: handle_full, status: ST_FOUND};
					end
				end
				default: begin
					n_phase = PH_IDLE;
				end
			endcase
		end

		// A result ends the scan
		if (emit) begin
			n_phase = PH_IDLE;
		end
	end

	// Hold the byte only when its result has nowhere to go
	assign consume  = item.valid && (!emit || out_free);
	assign out_load = '{load: consume && emit, res: res};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_offset_q    <= '0;
			record_begin_q   <= '0;
			phase_q          <= PH_IDLE;
			header_index_q   <= '0;
			formatted_left_q <= '0;
			handle_lo_q      <= '0;
			last_zero_q      <= 1'b0;
			match_seen_q     <= 1'b0;
			match_begin_q    <= '0;
			match_length_q   <= '0;
		end else if (consume) begin
			byte_offset_q    <= n_offset;
			record_begin_q   <= n_begin;
			phase_q          <= n_phase;
			header_index_q   <= n_index;
			formatted_left_q <= n_left;
			handle_lo_q      <= n_hlo;
			last_zero_q      <= n_lz;
			match_seen_q     <= n_mseen;
			match_begin_q    <= n_mbegin;
			match_length_q   <= n_mlen;
		end
	end

endmodule

/* src/smbw_out_reg.sv */
module smbw_out_reg
	import smbw_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  out_load_t        out_load,
	output logic             out_free,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata
);

	logic    valid_q;
	result_t res_q;

	// Slot frees when empty or when the held item leaves
	assign out_free = !valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (out_load.load) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load.load) begin
			res_q <= out_load.res;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = {{(OUT_W - OUT_BITS){1'b0}}, res_q};

endmodule

/* src/smbios_record_walker.sv */
// Channel  Dir  Payload (lowest bit first)
// s_*      in   tdata: data_byte[7:0]; tuser: start_of_table
// m_*      out  tdata: status[1:0], next_handle[17:2], record_offset[49:18],
//                      record_length[65:50], zero[71:66]
// cfg_*    in   cfg_addr 0 wanted_handle, 1 table_length; cfg_wdata[31:0]
//
// One byte per cycle while no result is stalled; a taken byte is held in the input
// register and parsed out of it, and its result is loaded into the output register,
// which drives m_tvalid until the result leaves.
// The single record parser register set bounds the rate at one byte a cycle.
// arst_n clears the parser to idle and empties both stages; wanted_handle
// resets to 0xFFFF and table_length to 0.
// A stalled result only holds back a byte that would itself give a result.
module smbios_record_walker
	import smbw_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [7:0]            s_tdata,   // data_byte[7:0]
	input  logic                  s_tuser,   // start_of_table
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_W-1:0]      m_tdata,   // status, next_handle, offset, length
	input  logic                  cfg_we,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [31:0]           cfg_wdata
);

	logic [15:0] wanted_handle_q;
	logic [31:0] table_length_q;
	in_item_t    item;
	logic        consume;
	logic        out_free;
	out_load_t   out_load;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wanted_handle_q <= NO_HANDLE;
			table_length_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_WANTED_HANDLE: wanted_handle_q <= cfg_wdata[15:0];
				REG_TABLE_LENGTH:  table_length_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	smbw_in_reg u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.consume  (consume),
		.item     (item)
	);

	smbw_parser u_parser (
		.clk           (clk),
		.arst_n        (arst_n),
		.item          (item),
		.out_free      (out_free),
		.wanted_handle (wanted_handle_q),
		.table_length  (table_length_q),
		.consume       (consume),
		.out_load      (out_load)
	);

	smbw_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.out_load (out_load),
		.out_free (out_free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

/* src/smbw_checker.sv */
`include "smbios_record_walker_macros.svh"

module smbw_checker
	import smbw_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             m_tvalid,
	input logic             m_tready,
	input logic [OUT_W-1:0] m_tdata
);

	// Stalled result stays offered and unchanged
	`SMBW_ASSERT_NEXT(a_hold_valid, m_tvalid && !m_tready, m_tvalid)
	`SMBW_ASSERT_NEXT(a_hold_data, m_tvalid && !m_tready, $stable(m_tdata))

	// Not found carries no handle, offset or length
	`SMBW_ASSERT_NOW(a_miss_fields, m_tvalid && m_tdata[1:0] == ST_NOT_FOUND, m_tdata[17:2] == NO_HANDLE && m_tdata[65:18] == '0)

	// First-handle result carries no offset or length, and padding stays zero
	`SMBW_ASSERT_NOW(a_first_fields, m_tvalid && m_tdata[1:0] == ST_FIRST, m_tdata[71:18] == '0)

endmodule

bind smbios_record_walker smbw_checker u_smbw_checker (.*);

/* sim/tb_smbios_record_walker.sv */
module tb_smbios_record_walker;
	import smbw_pkg::*;

	localparam int RAND_ITEMS  = 2000;
	localparam int DRAIN       = 8;
	localparam int HOLD_CYCLES = 400;

	typedef enum logic [1:0] {ROW_WANTED, ROW_LENGTH, ROW_BYTE} row_kind_t;

	// Directed row: kind, value (register data or byte), start, typed flag, typed result
	typedef struct packed {
		row_kind_t   kind;
		logic [31:0] val;
		logic        st;
		logic        typed;
		logic [1:0]  status;
		logic [15:0] nh;
		logic [31:0] off;
		logic [15:0] len;
	} row_t;

	typedef struct {
		logic [7:0] data;
		logic       start;
		bit         typed;
		result_t    res;
	} byte_item_t;

	localparam row_t DIR_ROWS [0:30] = '{
		// first handle asked, straight after reset
		'{ROW_BYTE,   32'h00,        1'b1, 1'b0, '0,           '0,       '0, '0},
		'{ROW_BYTE,   32'h02,        1'b0, 1'b0, '0,           '0,       '0, '0},
		'{ROW_BYTE,   32'h34,        1'b0, 1'b0, '0,           '0,       '0, '0},
		'{ROW_BYTE,   32'h12,        1'b0, 1'b1, ST_FIRST,     16'h1234, '0, '0},
		// idle byte, ignored
		'{ROW_BYTE,   32'hAA,        1'b0, 1'b0, '0,           '0,       '0, '0},
		// empty table
		'{ROW_WANTED, 32'h0000,      1'b0, 1'b0, '0,           '0,       '0, '0},
		'{ROW_BYTE,   32'hFF,        1'b1, 1'b1, ST_NOT_FOUND, NO_HANDLE, '0, '0},
		// match followed by the next header
		'{ROW_LENGTH, 32'hFFFFFFFF,  1'b0, 1'b0, '0,           '0,       '0, '0},
		'{ROW_WANTED, 32'hFFFE,      1'b0, 1'b0, '0,           '0,       '0, '0},
		'{ROW_BYTE,   32'hFF,        1'b1, 1'b0, '0,           '0,       '0, '0},
		'{ROW_BYTE,   32'h05,        1'b0, 1'b0, '0,           '0,       '0, '0},
		'{ROW_BYTE,   32'hFE,        1'b0, 1'b0, '0,           '0,       '0, '0},
		'{ROW_BYTE,   32'hFF,        1'b0, 1'b0, '0,           '0,       '0, '0},
		'{ROW_BYTE,   32'h00,        1'b0, 1'b0, '0,           '0,       '0, '0},
		'{ROW_BYTE,   32'h41,        1'b0, 1'b0, '0,           '0,       '0, '0},
		'{ROW_BYTE,   32'h00,        1'b0, 1'b0, '0,           '0,       '0, '0},
		'{ROW_BYTE,   32'h00,        1'b0, 1'b0, '0,           '0,       '0, '0},
		'{ROW_BYTE,   32'h80,        1'b0, 1'b0, '0,           '0,       '0, '0},
		'{ROW_BYTE,   32'h04,        1'b0, 1'b0, '0,           '0,       '0, '0},
		'{ROW_BYTE,   32'h00,        1'b0, 1'b0, '0,           '0,       '0, '0},
		'{ROW_BYTE,   32'h00,        1'b0, 1'b0, '0,           '0,       '0, '0},
		// restart mid-scan, then a match that reaches the table end
		'{ROW_LENGTH, 32'd6,         1'b0, 1'b0, '0,           '0,       '0, '0},
		'{ROW_WANTED, 32'h0001,      1'b0, 1'b0, '0,           '0,       '0, '0},
		'{ROW_BYTE,   32'h01,        1'b1, 1'b0, '0,           '0,       '0, '0},
		'{ROW_BYTE,   32'h04,        1'b0, 1'b0, '0,           '0,       '0, '0},
		'{ROW_BYTE,   32'h01,        1'b1, 1'b0, '0,           '0,       '0, '0},
		'{ROW_BYTE,   32'h04,        1'b0, 1'b0, '0,           '0,       '0, '0},
		'{ROW_BYTE,   32'h01,        1'b0, 1'b0, '0,           '0,       '0, '0},
		'{ROW_BYTE,   32'h00,        1'b0, 1'b0, '0,           '0,       '0, '0},
		'{ROW_BYTE,   32'h00,        1'b0, 1'b0, '0,           '0,       '0, '0},
		'{ROW_BYTE,   32'h00,        1'b0, 1'b1, ST_FOUND,     NO_HANDLE, '0, 16'd6}
	};

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [7:0]            s_tdata = '0;   // data_byte[7:0]
	logic                  s_tuser = 1'b0; // start_of_table
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_W-1:0]      m_tdata;        // status, next_handle, offset, length, zero pad
	logic                  cfg_we = 1'b0;
	logic [CFG_ADDR_W-1:0] cfg_addr = REG_WANTED_HANDLE;
	logic [31:0]           cfg_wdata = '0;

	// Walker model state and registers
	logic [15:0] want_handle = NO_HANDLE;
	logic [31:0] tbl_len = '0;
	logic [31:0] scan_pos = '0;
	logic [31:0] rec_start = '0;
	phase_t      phase = PH_IDLE;
	logic [2:0]  hdr_idx = '0;
	logic [7:0]  fmt_left = '0;
	logic [15:0] handle_acc = '0;
	logic        prev_zero = 1'b0;
	logic        hit = 1'b0;
	logic [31:0] hit_start = '0;
	logic [15:0] hit_len = '0;

	byte_item_t  tx_q[$];
	result_t     want_q[$];
	logic [7:0]  tbl_bytes[$];
	logic [15:0] tbl_handles[$];

	int unsigned cyc = 0;
	int unsigned err_count = 0;
	int unsigned bytes_taken = 0;
	int unsigned fed_bytes = 0;
	int unsigned scan_count = 0;
	int unsigned n_found = 0;
	int unsigned n_first = 0;
	int unsigned n_missing = 0;
	int unsigned hold_asks = 0;
	int unsigned hold_seen = 0;
	int unsigned hold_left = 0;
	bit          s_took = 1'b0;
	logic        quiet;

	assign quiet = (cyc % 2000) >= 1400;

	smbios_record_walker i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// End a scan with a result and go idle
	function automatic result_t close_scan(input logic [1:0] st, input logic [15:0] nh,
		input logic [31:0] off, input logic [15:0] len);
		result_t r;
		phase = PH_IDLE;
		r.status = st;
		r.next_handle = nh;
		r.record_offset = off;
		r.record_length = len;
		return r;
	endfunction

	// Advance the walker by one byte; return 1 when the byte ends the scan with a result
	function automatic bit walk_byte(input logic [7:0] b, input logic st, output result_t r);
		logic [31:0] here;
		logic [32:0] nxt;
		logic [32:0] span;
		r = '0;
		if (st) begin
			scan_pos = '0;
			rec_start = '0;
			hit = 1'b0;
			hit_start = '0;
			hit_len = '0;
			hdr_idx = '0;
			fmt_left = '0;
			handle_acc = '0;
			prev_zero = 1'b0;
			phase = PH_HEADER;
			if (want_handle != NO_HANDLE && tbl_len == '0) begin
				r = close_scan(ST_NOT_FOUND, NO_HANDLE, '0, '0);
				return 1'b1;
			end
		end
		if (phase == PH_IDLE)
			return 1'b0;
		here = scan_pos;
		if (scan_pos != OFFSET_MAX)
			scan_pos = scan_pos + 32'd1;
		case (phase)
			PH_HEADER: begin
				if (hdr_idx == 3'd3) begin
					handle_acc[15:8] = b;
					if (want_handle == NO_HANDLE) begin
						r = close_scan(ST_FIRST, handle_acc, '0, '0);
						return 1'b1;
					end
					if (handle_acc == want_handle) begin
						hit = 1'b1;
						hit_start = rec_start;
					end
					hdr_idx = '0;
					prev_zero = 1'b0;
					phase = (fmt_left != 8'd0) ? PH_FORMATTED : PH_STRINGS;
					return 1'b0;
				end
				if (hdr_idx == 3'd1)
					fmt_left = (b < 8'd4) ? 8'd0 : b - 8'd4;
				else if (hdr_idx == 3'd2)
					handle_acc = {8'h00, b};
				hdr_idx = hdr_idx + 3'd1;
			end
			PH_FORMATTED: begin
				fmt_left = fmt_left - 8'd1;
				if (fmt_left == 8'd0) begin
					prev_zero = 1'b0;
					phase = PH_STRINGS;
				end
			end
			PH_STRINGS: begin
				if (b == 8'd0 && prev_zero) begin
					nxt = {1'b0, here} + 33'd1;
					if (hit) begin
						span = nxt - {1'b0, hit_start};
						hit_len = (span > 33'h0FFFF) ? 16'hFFFF : span[15:0];
						if (nxt >= {1'b0, tbl_len}) begin
							r = close_scan(ST_FOUND, NO_HANDLE, hit_start, hit_len);
							return 1'b1;
						end
						hdr_idx = '0;
						phase = PH_NEXT;
						return 1'b0;
					end
					if (nxt >= {1'b0, tbl_len}) begin
						r = close_scan(ST_NOT_FOUND, NO_HANDLE, '0, '0);
						return 1'b1;
					end
					rec_start = nxt[31:0];
					hdr_idx = '0;
					phase = PH_HEADER;
					return 1'b0;
				end
				prev_zero = (b == 8'd0);
			end
			PH_NEXT: begin
				if (hdr_idx == 3'd2) begin
					handle_acc = {8'h00, b};
				end else if (hdr_idx == 3'd3) begin
					handle_acc[15:8] = b;
					r = close_scan(ST_FOUND, handle_acc, hit_start, hit_len);
					return 1'b1;
				end
				hdr_idx = hdr_idx + 3'd1;
			end
			default: phase = PH_IDLE;
		endcase
		return 1'b0;
	endfunction

	task automatic note_error(input string what, input logic [31:0] got, input logic [31:0] exp);
		$display("%0t mismatch %s: got %h, expected %h", $time, what, got, exp);
		err_count++;
	endtask

	// Compare one result item with the oldest expected result
	task automatic check_result(input logic [OUT_W-1:0] d);
		result_t g;
		result_t e;
		g = d[OUT_BITS-1:0];
		if (want_q.size() == 0) begin
			note_error("unexpected result, status", 32'(g.status), '0);
			return;
		end
		e = want_q.pop_front();
		if (g.status != e.status)
			note_error("status", 32'(g.status), 32'(e.status));
		if (g.next_handle != e.next_handle)
			note_error("next_handle", 32'(g.next_handle), 32'(e.next_handle));
		if (g.record_offset != e.record_offset)
			note_error("record_offset", g.record_offset, e.record_offset);
		if (g.record_length != e.record_length)
			note_error("record_length", 32'(g.record_length), 32'(e.record_length));
		if (d[OUT_W-1:OUT_BITS] != '0)
			note_error("tdata pad", 32'(d[OUT_W-1:OUT_BITS]), '0);
		case (e.status)
			ST_FOUND: n_found++;
			ST_FIRST: n_first++;
			default:  n_missing++;
		endcase
	endtask

	// Sample both channels; predict on each accepted byte, check each accepted result
	always @(posedge clk) begin : monitor
		byte_item_t it;
		result_t    pred;
		bit         has;
		cyc++;
		s_took = arst_n && s_tvalid && s_tready;
		if (s_took) begin
			it = tx_q.pop_front();
			has = walk_byte(it.data, it.start, pred);
			if (it.typed)
				want_q.push_back(it.res);
			else if (has)
				want_q.push_back(pred);
			bytes_taken++;
		end
		if (arst_n && m_tvalid && m_tready)
			check_result(m_tdata);
	end

	// Offer bytes; hold an item until it is taken, idle at random otherwise
	always @(negedge clk) begin
		if (s_tvalid && !s_took) begin
			s_tvalid <= 1'b1;
		end else if (tx_q.size() != 0 && (quiet || $urandom_range(0, 99) >= 25)) begin
			s_tvalid <= 1'b1;
			s_tdata <= tx_q[0].data;
			s_tuser <= tx_q[0].start;
		end else begin
			s_tvalid <= 1'b0;
		end
	end

	// Accept results; stall at random, or for a long stretch when asked
	always @(negedge clk) begin
		if (hold_left != 0) begin
			hold_left = hold_left - 1;
			m_tready <= 1'b0;
		end else if (hold_asks != hold_seen) begin
			hold_seen = hold_asks;
			hold_left = HOLD_CYCLES;
			m_tready <= 1'b0;
		end else begin
			m_tready <= quiet || $urandom_range(0, 99) >= 25;
		end
	end

	task automatic send_byte(input logic [7:0] d, input logic st, input bit tp = 1'b0,
		input result_t r = '0);
		tx_q.push_back('{data: d, start: st, typed: tp, res: r});
	endtask

	// Wait until every byte is taken and every result is back, then let the block settle
	task automatic settle();
		while (tx_q.size() != 0 || want_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [31:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_WANTED_HANDLE)
			want_handle = v[15:0];
		else
			tbl_len = v;
	endtask

	// Build a well-formed structure table; a nonzero long_len stretches the first record's strings
	task automatic make_table(input int nrec, input int long_len);
		logic [15:0] h;
		logic [7:0]  lenb;
		int          nstr;
		tbl_bytes.delete();
		tbl_handles.delete();
		for (int r = 0; r < nrec; r++) begin
			case ($urandom_range(0, 9))
				0: h = 16'h0000;
				1: h = 16'hFFFE;
				2: h = NO_HANDLE;
				default: h = 16'($urandom);
			endcase
			case ($urandom_range(0, 19))
				0, 1: lenb = 8'($urandom_range(0, 3));
				2: lenb = 8'hFF;
				default: lenb = 8'($urandom_range(4, 14));
			endcase
			tbl_handles.push_back(h);
			tbl_bytes.push_back(8'($urandom));
			tbl_bytes.push_back(lenb);
			tbl_bytes.push_back(h[7:0]);
			tbl_bytes.push_back(h[15:8]);
			for (int i = 4; i < int'(lenb); i++)
				tbl_bytes.push_back(($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom));
			if (r == 0 && long_len > 0) begin
				repeat (long_len) tbl_bytes.push_back(8'($urandom_range(1, 255)));
				tbl_bytes.push_back(8'h00);
			end else begin
				nstr = $urandom_range(0, 3);
				if (nstr == 0)
					tbl_bytes.push_back(8'h00);
				repeat (nstr) begin
					repeat ($urandom_range(1, 6)) tbl_bytes.push_back(8'($urandom_range(1, 255)));
					tbl_bytes.push_back(8'h00);
				end
			end
			tbl_bytes.push_back(8'h00);
		end
	endtask

	// Queue the first n bytes of the built table as one scan
	task automatic send_scan(input int n);
		for (int i = 0; i < n; i++)
			send_byte(tbl_bytes[i], i == 0);
		fed_bytes += n;
		scan_count++;
	endtask

	initial begin : stimulus
		result_t     r;
		logic [15:0] want;
		logic [31:0] len;
		int          total;
		int          n;

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed table
		for (int i = 0; i < $size(DIR_ROWS); i++) begin
			case (DIR_ROWS[i].kind)
				ROW_WANTED: begin
					settle();
					write_reg(REG_WANTED_HANDLE, DIR_ROWS[i].val);
				end
				ROW_LENGTH: begin
					settle();
					write_reg(REG_TABLE_LENGTH, DIR_ROWS[i].val);
				end
				default: begin
					r.status = DIR_ROWS[i].status;
					r.next_handle = DIR_ROWS[i].nh;
					r.record_offset = DIR_ROWS[i].off;
					r.record_length = DIR_ROWS[i].len;
					send_byte(DIR_ROWS[i].val[7:0], DIR_ROWS[i].st, DIR_ROWS[i].typed, r);
					if (DIR_ROWS[i].st)
						scan_count++;
				end
			endcase
		end
		settle();

		// Random phases: one setting, a few scans each
		while (fed_bytes < RAND_ITEMS) begin
			make_table($urandom_range(1, 5), 0);
			total = tbl_bytes.size();
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4: want = tbl_handles[$urandom_range(0, tbl_handles.size() - 1)];
				5, 6: want = NO_HANDLE;
				default: want = 16'($urandom);
			endcase
			case ($urandom_range(0, 9))
				0: len = '0;
				1: len = OFFSET_MAX;
				2: len = $urandom;
				3: len = $urandom_range(0, total);
				4: len = total + $urandom_range(1, 30);
				default: len = total;
			endcase
			write_reg(REG_WANTED_HANDLE, {16'h0000, want});
			write_reg(REG_TABLE_LENGTH, len);
			repeat ($urandom_range(1, 3)) begin
				case ($urandom_range(0, 9))
					0: begin
						// noise scan
						n = $urandom_range(3, 30);
						send_byte(8'($urandom), 1'b1);
						repeat (n)
							send_byte(($urandom_range(0, 2) == 0) ? 8'h00 : 8'($urandom), 1'b0);
						fed_bytes += n + 1;
						scan_count++;
					end
					1: send_scan($urandom_range(1, tbl_bytes.size() - 1));
					default: send_scan(tbl_bytes.size());
				endcase
				repeat ($urandom_range(0, 2)) send_byte(8'($urandom), 1'b0);
				make_table($urandom_range(1, 5), 0);
			end
			settle();
		end

		// Hold off results while short first-handle scans keep coming
		write_reg(REG_WANTED_HANDLE, {16'h0000, NO_HANDLE});
		hold_asks++;
		repeat (30) begin
			send_byte(8'($urandom), 1'b1);
			repeat (3) send_byte(8'($urandom), 1'b0);
			scan_count++;
		end
		settle();

		repeat (20) @(posedge clk);
		if (want_q.size() != 0)
			note_error("results never delivered", want_q.size(), '0);
		$display("summary: %0d bytes over %0d scans, %0d results checked", bytes_taken,
			scan_count, n_found + n_first + n_missing);
		$display("summary: %0d found, %0d first handle, %0d not found, %0d mismatches",
			n_found, n_first, n_missing, err_count);
		if (err_count == 0) begin
			$display("tb_smbios_record_walker: clean");
		end else begin
			$display("tb_smbios_record_walker: errors");
		end
		$finish;
	end

	// Give up on a hung run
	initial begin
		#4000000;
		$display("tb_smbios_record_walker: errors");
		$finish;
	end

endmodule
